### rtl/shift_xor_twister_word_generator_defines.svh
`ifndef SHIFT_XOR_TWISTER_WORD_GENERATOR_DEFINES_SVH
`define SHIFT_XOR_TWISTER_WORD_GENERATOR_DEFINES_SVH

// Checks that hold in the same cycle as their condition.
`define SWX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that hold in the cycle after their condition.
`define SWX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/swx_pkg.sv
`timescale 1ns / 1ps

package swx_pkg;

    localparam int STORE_WORDS_DEF = 624;
    localparam int WORD_W          = 32;
    localparam int TAP_W           = 10;
    localparam int SHIFT_W         = 5;
    localparam int CFG_DATA_W      = 10;
    localparam int CFG_INDEX_W     = 2;
    localparam int BACK_DIST       = 4;
    localparam int SEED_SHIFT      = 30;

    localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;

    localparam logic [TAP_W-1:0]   TAP_RESET        = 10'd11;
    localparam logic [SHIFT_W-1:0] SHIFT_SELF_RESET = 5'd5;
    localparam logic [SHIFT_W-1:0] SHIFT_TAP_RESET  = 5'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_BACK_RESET = 5'd1;

    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TAP_DISTANCE     = 2'd0,
        CFG_SHIFT_LEFT_SELF  = 2'd1,
        CFG_SHIFT_LEFT_TAP   = 2'd2,
        CFG_SHIFT_RIGHT_BACK = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [SHIFT_W-1:0] sl_self;
        logic [SHIFT_W-1:0] sl_tap;
        logic [SHIFT_W-1:0] sr_back;
    } t_shift_cfg;

    function automatic logic [WORD_W-1:0] swx_mix(
        input logic [WORD_W-1:0] w,
        input logic [WORD_W-1:0] t,
        input logic [WORD_W-1:0] b,
        input t_shift_cfg        c
    );
        return (w << c.sl_self) ^ w ^ (t << c.sl_tap) ^ t ^ (b >> c.sr_back) ^ b;
    endfunction

endpackage

### rtl/swx_store.sv
`timescale 1ns / 1ps

module swx_store
    import swx_pkg::*;
#(
    parameter int DEPTH = STORE_WORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_wa,
    input  logic [WORD_W-1:0] i_wd,
    input  logic [AW-1:0]     i_ra,
    input  logic [AW-1:0]     i_rb,
    output logic [WORD_W-1:0] o_rd_a,
    output logic [WORD_W-1:0] o_rd_b
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_a;
    logic [WORD_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_rd_a <= r_mem[i_ra];
        r_rd_b <= r_mem[i_rb];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

### rtl/swx_engine.sv
`timescale 1ns / 1ps

module swx_engine
    import swx_pkg::*;
#(
    parameter int DEPTH = STORE_WORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic [WORD_W-1:0]  i_seed_value,
    input  logic [TAP_W-1:0]   i_tap,
    input  t_shift_cfg         i_shift,
    input  logic               i_slot_free,
    output logic               o_res_valid,
    output logic [WORD_W-1:0]  o_res_word,
    output logic               o_we,
    output logic [AW-1:0]      o_wa,
    output logic [WORD_W-1:0]  o_wd,
    output logic [AW-1:0]      o_ra,
    output logic [AW-1:0]      o_rb,
    input  logic [WORD_W-1:0]  i_rd_a,
    input  logic [WORD_W-1:0]  i_rd_b
);

    localparam int TW = (AW + 1 > TAP_W) ? AW + 1 : TAP_W;
    localparam int PW = $clog2(BACK_DIST + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_WR,
        S_SEED_ADV,
        S_REDUCE,
        S_PRELOAD,
        S_REGEN,
        S_DRAW
    } t_state;

    t_state            r_state, n_state;
    logic              r_seeded, n_seeded;
    logic [AW:0]       r_rd_pos, n_rd_pos;
    logic [AW-1:0]     r_idx, n_idx;
    logic [WORD_W-1:0] r_seed, n_seed;
    logic [WORD_W-1:0] r_prod, n_prod;
    logic [TW-1:0]     r_tap, n_tap;
    logic [PW-1:0]     r_pre, n_pre;
    logic [AW-1:0]     r_tb, n_tb;
    logic              r_fwd, n_fwd;
    logic [WORD_W-1:0] r_back [BACK_DIST];
    logic              w_push;
    logic [WORD_W-1:0] w_push_word;
    logic [WORD_W-1:0] w_tap_word;
    logic [WORD_W-1:0] w_new_word;
    logic [WORD_W-1:0] w_fold;
    logic [AW-1:0]     w_tb_next;
    logic              w_used_up;

    assign w_used_up  = (r_rd_pos >= (AW + 1)'(DEPTH));
    assign w_tap_word = r_fwd ? r_back[BACK_DIST-1] : i_rd_b;
    assign w_new_word = swx_mix(i_rd_a, w_tap_word, r_back[0], i_shift);
    assign w_fold     = r_seed ^ (r_seed >> SEED_SHIFT);
    assign w_tb_next  = (r_tb == AW'(DEPTH - 1)) ? '0 : r_tb + AW'(1);

    always_comb begin
        n_state     = r_state;
        n_seeded    = r_seeded;
        n_rd_pos    = r_rd_pos;
        n_idx       = r_idx;
        n_seed      = r_seed;
        n_prod      = r_prod;
        n_tap       = r_tap;
        n_pre       = r_pre;
        n_tb        = r_tb;
        n_fwd       = r_fwd;
        w_push      = 1'b0;
        w_push_word = w_new_word;
        o_in_ready  = (r_state == S_IDLE);
        o_res_valid = 1'b0;
        o_res_word  = r_seeded ? i_rd_a : '0;
        o_we        = 1'b0;
        o_wa        = r_idx;
        o_wd        = w_new_word;
        o_ra        = r_rd_pos[AW-1:0];
        o_rb        = r_tb;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_SEED) begin
                        n_seed  = i_seed_value;
                        n_idx   = '0;
                        n_state = S_SEED_WR;
                    end else if (!w_used_up) begin
                        n_state = S_DRAW;
                    end else if (r_seeded) begin
                        n_tap   = TW'(i_tap);
                        n_state = S_REDUCE;
                    end else begin
                        n_rd_pos = '0;
                        o_ra     = '0;
                        n_state  = S_DRAW;
                    end
                end
            end
            S_SEED_WR: begin
                o_we   = 1'b1;
                o_wd   = r_seed;
                n_prod = SEED_MULT * w_fold;
                if (r_idx == AW'(DEPTH - 1)) begin
                    n_seeded = 1'b1;
                    n_rd_pos = (AW + 1)'(DEPTH);
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SEED_ADV;
                end
            end
            S_SEED_ADV: begin
                n_seed  = r_prod + WORD_W'(r_idx);
                n_idx   = r_idx + AW'(1);
                n_state = S_SEED_WR;
            end
            S_REDUCE: begin
                if (r_tap >= TW'(DEPTH)) begin
                    n_tap = r_tap - TW'(DEPTH);
                end else begin
                    n_pre   = '0;
                    n_state = S_PRELOAD;
                end
            end
            S_PRELOAD: begin
                o_ra        = AW'(DEPTH - BACK_DIST) + AW'(r_pre);
                w_push_word = i_rd_a;
                w_push      = (r_pre != '0);
                if (r_pre == PW'(BACK_DIST)) begin
                    o_ra    = '0;
                    o_rb    = r_tap[AW-1:0];
                    n_tb    = r_tap[AW-1:0];
                    n_idx   = '0;
                    n_fwd   = 1'b0;
                    n_state = S_REGEN;
                end else begin
                    n_pre = r_pre + PW'(1);
                end
            end
            S_REGEN: begin
                o_we   = 1'b1;
                w_push = 1'b1;
                if (r_idx == AW'(DEPTH - 1)) begin
                    n_rd_pos = '0;
                    o_ra     = '0;
                    n_state  = S_DRAW;
                end else begin
                    n_idx = r_idx + AW'(1);
                    o_ra  = r_idx + AW'(1);
                    o_rb  = w_tb_next;
                    n_tb  = w_tb_next;
                    n_fwd = (w_tb_next == r_idx);
                end
            end
            S_DRAW: begin
                if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    n_rd_pos    = r_rd_pos + (AW + 1)'(1);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seeded <= 1'b0;
            r_rd_pos <= '0;
        end else begin
            r_state  <= n_state;
            r_seeded <= n_seeded;
            r_rd_pos <= n_rd_pos;
        end
        r_idx  <= n_idx;
        r_seed <= n_seed;
        r_prod <= n_prod;
        r_tap  <= n_tap;
        r_pre  <= n_pre;
        r_tb   <= n_tb;
        r_fwd  <= n_fwd;
        if (w_push) begin
            for (int k = 0; k < BACK_DIST - 1; k++) begin
                r_back[k] <= r_back[k+1];
            end
            r_back[BACK_DIST-1] <= w_push_word;
        end
    end

endmodule

### rtl/shift_xor_twister_word_generator.sv
`timescale 1ns / 1ps
// Channel   Signals                               Moves
// input     i_in_valid / o_in_ready               i_kind, i_seed_value
// output    o_out_valid / i_out_ready             o_random_word
// config    i_cfg_we, i_cfg_index, i_cfg_data     one register per write
//
// A draw reads the word store, then hands the word on to the output register.
// The first draw after a seed, and after each further STORE_WORDS draws, adds a pass that
// reduces the tap, preloads the back words and regenerates the store, one word per cycle.
// Before any seed the store reads as zero and draws never regenerate it.
// A seed writes each store word and works out the next one in the seed multiplier loop.
// Reset needs no clearing pass; a stalled output word holds the engine in its draw.

module shift_xor_twister_word_generator
    import swx_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_kind,
    input  logic [WORD_W-1:0]      i_seed_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [WORD_W-1:0]      o_random_word,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

`include "shift_xor_twister_word_generator_defines.svh"

    localparam int AW = $clog2(STORE_WORDS);

    logic [TAP_W-1:0]  r_tap;
    t_shift_cfg        r_shift;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              w_slot_free;
    logic              w_res_valid;
    logic [WORD_W-1:0] w_res_word;
    logic              w_we;
    logic [AW-1:0]     w_wa;
    logic [WORD_W-1:0] w_wd;
    logic [AW-1:0]     w_ra;
    logic [AW-1:0]     w_rb;
    logic [WORD_W-1:0] w_rd_a;
    logic [WORD_W-1:0] w_rd_b;

    assign w_slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap           <= TAP_RESET;
            r_shift.sl_self <= SHIFT_SELF_RESET;
            r_shift.sl_tap  <= SHIFT_TAP_RESET;
            r_shift.sr_back <= SHIFT_BACK_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TAP_DISTANCE:     r_tap           <= i_cfg_data;
                CFG_SHIFT_LEFT_SELF:  r_shift.sl_self <= i_cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_LEFT_TAP:   r_shift.sl_tap  <= i_cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_RIGHT_BACK: r_shift.sr_back <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid) begin
            r_out_word <= w_res_word;
        end
    end

    swx_engine #(
        .DEPTH (STORE_WORDS),
        .AW    (AW)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_seed_value (i_seed_value),
        .i_tap        (r_tap),
        .i_shift      (r_shift),
        .i_slot_free  (w_slot_free),
        .o_res_valid  (w_res_valid),
        .o_res_word   (w_res_word),
        .o_we         (w_we),
        .o_wa         (w_wa),
        .o_wd         (w_wd),
        .o_ra         (w_ra),
        .o_rb         (w_rb),
        .i_rd_a       (w_rd_a),
        .i_rd_b       (w_rd_b)
    );

    swx_store #(
        .DEPTH (STORE_WORDS),
        .AW    (AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_wa   (w_wa),
        .i_wd   (w_wd),
        .i_ra   (w_ra),
        .i_rb   (w_rb),
        .o_rd_a (w_rd_a),
        .o_rd_b (w_rd_b)
    );

    `SWX_ASSERT_NOW(a_no_overwrite, w_res_valid, w_slot_free, "A word would overwrite a pending output.")
    `SWX_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "Engine took a second word at once.")
    `SWX_ASSERT_NOW(a_write_in_range, w_we, w_wa <= AW'(STORE_WORDS - 1), "Store write beyond its depth.")

endmodule

### test/tb_shift_xor_twister_word_generator.sv
`timescale 1ns / 1ps

module tb_shift_xor_twister_word_generator;
    import swx_pkg::*;

    localparam int SETTLE_CYCLES = 2 * STORE_WORDS_DEF + 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_PHASES    = 8;
    localparam int HOLD_PHASE    = 5;
    localparam int MAX_REPORTS   = 100;

    class word_store_mirror;
        logic [WORD_W-1:0]  store [STORE_WORDS_DEF];
        int unsigned        read_pos;
        logic [TAP_W-1:0]   tap_distance;
        logic [SHIFT_W-1:0] shl_self;
        logic [SHIFT_W-1:0] shl_tap;
        logic [SHIFT_W-1:0] shr_back;
        logic [WORD_W-1:0]  pending_words [$];
        int                 mismatches;
        int                 seeds;
        int                 draws;
        int                 checked;

        function new();
            foreach (store[i]) store[i] = '0;
            read_pos     = 0;
            tap_distance = TAP_RESET;
            shl_self     = SHIFT_SELF_RESET;
            shl_tap      = SHIFT_TAP_RESET;
            shr_back     = SHIFT_BACK_RESET;
            mismatches   = 0;
            seeds        = 0;
            draws        = 0;
            checked      = 0;
        endfunction

        function void write_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_TAP_DISTANCE:     tap_distance = value[TAP_W-1:0];
                CFG_SHIFT_LEFT_SELF:  shl_self     = value[SHIFT_W-1:0];
                CFG_SHIFT_LEFT_TAP:   shl_tap      = value[SHIFT_W-1:0];
                CFG_SHIFT_RIGHT_BACK: shr_back     = value[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        // Words are updated in place, so later words see earlier updates of the pass.
        function void twist_store();
            int unsigned       tap;
            logic [WORD_W-1:0] w;
            logic [WORD_W-1:0] t;
            logic [WORD_W-1:0] b;
            tap = tap_distance % STORE_WORDS_DEF;
            for (int unsigned i = 0; i < STORE_WORDS_DEF; i++) begin
                w = store[i];
                t = store[(i + tap) % STORE_WORDS_DEF];
                b = store[(i + STORE_WORDS_DEF - BACK_DIST) % STORE_WORDS_DEF];
                store[i] = w ^ (w << shl_self) ^ t ^ (t << shl_tap) ^ b ^ (b >> shr_back);
            end
        endfunction

        function void note_request(logic kind, logic [WORD_W-1:0] seed);
            logic [WORD_W-1:0] s;
            if (kind == KIND_SEED) begin
                s = seed;
                for (int unsigned i = 0; i < STORE_WORDS_DEF; i++) begin
                    store[i] = s;
                    s = SEED_MULT * (s ^ (s >> SEED_SHIFT)) + i;
                end
                read_pos = STORE_WORDS_DEF;
                seeds++;
            end else begin
                if (read_pos >= STORE_WORDS_DEF) begin
                    twist_store();
                    read_pos = 0;
                end
                pending_words.push_back(store[read_pos]);
                read_pos++;
                draws++;
            end
        endfunction

        function void check_word(logic [WORD_W-1:0] got);
            logic [WORD_W-1:0] want;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("random_word: expected none, actual %08h", got);
                return;
            end
            want = pending_words.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("random_word: expected %08h, actual %08h", want, got);
            end
        endfunction

        function void check_leftover();
            if (pending_words.size() != 0) begin
                mismatches += pending_words.size();
                $error("random_word: expected %08h and %0d more, actual none",
                       pending_words[0], pending_words.size() - 1);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_kind = KIND_SEED;
    logic [WORD_W-1:0]      in_seed = '0;
    logic                   out_ready = 1'b0;
    logic                   cfg_we = 1'b0;
    t_cfg_index             cfg_index = CFG_TAP_DISTANCE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [WORD_W-1:0]      o_random_word;

    bit                     steady_tail = 1'b0;
    bit                     hold_output = 1'b0;
    int                     settings_applied = 0;
    word_store_mirror       mirror = new();

    shift_xor_twister_word_generator dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (in_kind),
        .i_seed_value (in_seed),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_random_word(o_random_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] pick_seed_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(0, WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic offer_request(input logic kind, input logic [WORD_W-1:0] seed);
        if (!steady_tail && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_seed  <= seed;
        do @(posedge clk); while (!o_in_ready);
        mirror.note_request(kind, seed);
    endtask

    task automatic drain(input int settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (mirror.pending_words.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] tap, sl_self, sl_tap, sr_back,
                                  input logic [3:0] which);
        logic [CFG_DATA_W-1:0] vals [4];
        t_cfg_index            idx;
        vals = '{tap, sl_self, sl_tap, sr_back};
        idx  = idx.first();
        for (int r = 0; r < 4; r++) begin
            if (which[r]) begin
                cfg_we    <= 1'b1;
                cfg_index <= idx;
                cfg_data  <= vals[r];
                @(posedge clk);
                mirror.write_register(idx, vals[r]);
            end
            idx = idx.next();
        end
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    initial begin
        int   stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && o_out_valid && out_ready)
                mirror.check_word(o_random_word);
            if (hold_output) begin
                hold_output = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 18);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_shift_xor_twister_word_generator: FAIL");
        $finish;
    end

    initial begin
        int   n;
        int   lead;
        logic kind;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Draws before any seed, long enough to wrap the read position past the all-zero store once.
        repeat (STORE_WORDS_DEF + 2) offer_request(KIND_DRAW, $urandom);
        drain(SETTLE_CYCLES);

        offer_request(KIND_SEED, '0);
        repeat (2) offer_request(KIND_DRAW, $urandom);
        offer_request(KIND_SEED, '1);
        repeat (2) offer_request(KIND_DRAW, $urandom);
        drain(SETTLE_CYCLES);

        apply_settings(10'd0, 10'd0, 10'd0, 10'd0, 4'hF);
        offer_request(KIND_SEED, 32'h8000_0000);
        repeat (2) offer_request(KIND_DRAW, $urandom);
        drain(SETTLE_CYCLES);

        apply_settings(10'd1023, 10'd31, 10'd31, 10'd31, 4'hF);
        offer_request(KIND_SEED, 32'd1);
        repeat (2) offer_request(KIND_DRAW, $urandom);
        drain(SETTLE_CYCLES);

        // The new settings must not touch the words already in the store.
        apply_settings(10'd3, 10'h3E2, 10'h3FF, 10'h025, 4'hF);
        offer_request(KIND_DRAW, $urandom);
        offer_request(KIND_SEED, 32'h1234_5678);
        repeat (2) offer_request(KIND_DRAW, $urandom);
        drain(SETTLE_CYCLES);

        for (int p = 0; p < NUM_PHASES; p++) begin
            steady_tail = (p == NUM_PHASES - 1);
            case (p)
                0: apply_settings(10'd4, 10'd0, 10'd31, 10'd0, 4'hF);
                1: apply_settings(10'd619, 10'd31, 10'd0, 10'd31, 4'hF);
                2: apply_settings(10'd624, 10'h3FF, 10'h020, 10'h3E1, 4'hF);
                3: apply_settings(10'd623, 10'd13, 10'd7, 10'd3, 4'b0011);
                default: apply_settings(CFG_DATA_W'($urandom_range(0, 1023)),
                                        CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                        CFG_DATA_W'($urandom), 4'($urandom_range(1, 15)));
            endcase
            n    = (p == HOLD_PHASE) ? 40 : $urandom_range(4, 12);
            lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            for (int k = 0; k < n; k++) begin
                if (k < lead)
                    kind = KIND_DRAW;
                else if (k == lead)
                    kind = KIND_SEED;
                else
                    kind = ($urandom_range(0, 9) == 0) ? KIND_SEED : KIND_DRAW;
                offer_request(kind, pick_seed_value());
                if (p == HOLD_PHASE && k == 10)
                    hold_output = 1'b1;
                if (p == HOLD_PHASE && k == 35)
                    drain(0);
            end
            drain(SETTLE_CYCLES);
        end

        mirror.check_leftover();
        $display("Run covered %0d seeds and %0d draws under %0d register settings; %0d words checked.",
                 mirror.seeds, mirror.draws, settings_applied, mirror.checked);
        $display("It included draws on the unseeded store, shift and tap extremes and a long output stall.");
        if (mirror.mismatches == 0)
            $display("tb_shift_xor_twister_word_generator: PASS");
        else
            $display("tb_shift_xor_twister_word_generator: FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/swx_pkg.sv
rtl/swx_store.sv
rtl/swx_engine.sv
rtl/shift_xor_twister_word_generator.sv
test/tb_shift_xor_twister_word_generator.sv
